// ----- sv/i2c_master_status_sequencer_macros.svh -----
// Assertion helpers for the status sequencer checker.
`ifndef I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH
`define I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH

// Plain clocked property, off while reset is held.
`define I2CMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication.
`define I2CMS_IMPLY(lbl, ante, cons, msg) \
    `I2CMS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- sv/i2cms_pkg.sv -----
package i2cms_pkg;

    // item function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_BEGIN  = 2'd1;
    localparam logic [1:0] FUNC_STATUS = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0] CFG_BYTE_COUNT = 2'd1;
    localparam logic [1:0] CFG_RX_MODE    = 2'd2;
    localparam logic [1:0] CFG_START_IDX  = 2'd3;

    // controller status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_ADDRW_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDRW_NACK  = 8'h20;
    localparam logic [7:0] ST_TXDATA_ACK  = 8'h28;
    localparam logic [7:0] ST_TXDATA_NACK = 8'h30;
    localparam logic [7:0] ST_ADDRR_ACK   = 8'h40;
    localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RXDATA_NACK = 8'h58;

    localparam logic       RW_READ   = 1'b1;
    localparam logic [5:0] CMD_BYTES = 6'd2;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       send_start;
        logic       send_stop;
        logic       send_ack;
        logic       clear_flag;
        logic       rx_valid;
        logic [4:0] rx_index;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       timeout_clear;
        logic       unhandled;
    } t_result;

    // decode stage: result less the buffer byte, plus how to fill it in
    typedef struct packed {
        t_result res;
        logic    sel_ram;
        logic    ram_ok;
    } t_stage;

endpackage

// ----- sv/i2cms_ram.sv -----
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/i2c_master_status_sequencer.sv -----
// A result beat passes the decode register and then the register that merges in
// the buffer read; a stalled output holds both.
// Throughput: one item per cycle while the output is not stalled; the decode stage
// issues at most one buffer read and one buffer write per item; read data is registered.
// Reset (synchronous, active low) clears position, config registers and pipeline
// valids; the byte buffer is not cleared and holds garbage until written.
module i2c_master_status_sequencer #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_status_code,
    input  logic       i_timeout_seen,
    input  logic [7:0] i_rx_data,
    input  logic [4:0] i_load_index,
    input  logic [7:0] i_load_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_send_start,
    output logic       o_send_stop,
    output logic       o_send_ack,
    output logic       o_clear_flag,
    output logic       o_rx_valid,
    output logic [4:0] o_rx_index,
    output logic [7:0] o_rx_byte,
    output logic       o_done_res,
    output logic       o_timeout_clear,
    output logic       o_unhandled
);
    import i2cms_pkg::*;

    localparam int         AW    = $clog2(BUFFER_BYTES);
    localparam logic [8:0] DEPTH = 9'(BUFFER_BYTES);

    logic [6:0] r_dev_addr;
    logic [5:0] r_byte_count;
    logic       r_rx_mode;
    logic [4:0] r_start_index;
    logic [5:0] r_pos, n_pos;

    logic    r_s1_valid, n_s1_valid;
    t_stage  r_s1, n_s1;
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    logic       s1_adv, in_acc;
    logic [5:0] pos_inc;
    logic [8:0] pos_wide, load_wide;
    logic       pos_ok, load_ok;
    logic [7:0] addr_byte;
    logic       wr_en;
    logic [8:0] wr_idx;
    logic [7:0] wr_data;
    logic [7:0] rd_data;

    assign s1_adv    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || s1_adv;
    assign in_acc    = i_valid && o_ready;
    assign pos_inc   = r_pos + 6'd1;
    assign pos_wide  = {3'b000, r_pos};
    assign load_wide = {4'b0000, i_load_index};
    assign pos_ok    = pos_wide < DEPTH;
    assign load_ok   = load_wide < DEPTH;
    assign addr_byte = {r_dev_addr, 1'b0};

    // decode: everything but the buffer byte is known here
    always_comb begin
        n_s1    = '0;
        n_pos   = r_pos;
        wr_en   = 1'b0;
        wr_idx  = load_wide;
        wr_data = i_load_byte;
        unique case (i_func)
            FUNC_LOAD: begin
                wr_en = load_ok;
            end
            FUNC_BEGIN: begin
                n_pos              = {1'b0, r_start_index};
                n_s1.res.send_start = 1'b1;
            end
            FUNC_STATUS: begin
                priority if (i_timeout_seen) begin
                    n_s1.res.timeout_clear = 1'b1;
                end else begin
                    unique case (i_status_code)
                        ST_START: begin
                            n_s1.res.tx_valid   = 1'b1;
                            n_s1.res.tx_byte    = addr_byte | {7'd0, r_pos != 6'd0};
                            n_s1.res.clear_flag = 1'b1;
                        end
                        ST_RSTART: begin
                            n_s1.res.tx_valid   = 1'b1;
                            n_s1.res.tx_byte    = addr_byte | {7'd0, RW_READ};
                            n_s1.res.clear_flag = 1'b1;
                        end
                        ST_ADDRW_ACK: begin
                            n_s1.res.tx_valid   = 1'b1;
                            n_s1.res.clear_flag = 1'b1;
                            n_s1.sel_ram        = 1'b1;
                            n_s1.ram_ok         = pos_ok;
                            n_pos               = pos_inc;
                        end
                        ST_ADDRW_NACK, ST_TXDATA_NACK: begin
                            n_s1.res.send_start = 1'b1;
                            n_s1.res.send_stop  = 1'b1;
                            n_s1.res.clear_flag = 1'b1;
                        end
                        ST_TXDATA_ACK: begin
                            n_s1.res.clear_flag = 1'b1;
                            if ((r_rx_mode && r_pos < CMD_BYTES)
                                    || (!r_rx_mode && r_pos < r_byte_count)) begin
                                n_s1.res.tx_valid = 1'b1;
                                n_s1.sel_ram      = 1'b1;
                                n_s1.ram_ok       = pos_ok;
                                n_pos             = pos_inc;
                            end else if (r_rx_mode) begin
                                // command bytes out, turn around with repeated start
                                n_s1.res.send_start = 1'b1;
                            end else begin
                                n_s1.res.send_stop = 1'b1;
                                n_s1.res.done_res  = 1'b1;
                            end
                        end
                        ST_ADDRR_ACK: begin
                            n_s1.res.clear_flag = 1'b1;
                            n_s1.res.send_ack   =
                                ({1'b0, r_pos} + 7'd1) < {1'b0, r_byte_count};
                        end
                        ST_RXDATA_ACK, ST_RXDATA_NACK: begin
                            wr_en               = pos_ok;
                            wr_idx              = pos_wide;
                            wr_data             = i_rx_data;
                            n_s1.res.rx_valid   = 1'b1;
                            n_s1.res.rx_index   = r_pos[4:0];
                            n_s1.res.rx_byte    = i_rx_data;
                            n_s1.res.clear_flag = 1'b1;
                            n_pos               = pos_inc;
                            if (i_status_code == ST_RXDATA_ACK) begin
                                // ack test uses the already advanced position
                                n_s1.res.send_ack =
                                    ({1'b0, pos_inc} + 7'd1) < {1'b0, r_byte_count};
                            end else begin
                                n_s1.res.send_stop = 1'b1;
                                n_s1.res.done_res  = 1'b1;
                            end
                        end
                        default: begin
                            n_s1.res.unhandled = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_s1 = '0;
            end
        endcase
    end

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc && wr_en),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (in_acc),
        .i_raddr (pos_wide[AW-1:0]),
        .o_rdata (rd_data)
    );

    // merge the buffer byte into the result
    always_comb begin
        n_out = r_s1.res;
        if (r_s1.sel_ram) begin
            n_out.tx_byte = r_s1.ram_ok ? rd_data : 8'd0;
        end
    end

    assign n_s1_valid  = in_acc || (r_s1_valid && !s1_adv);
    assign n_out_valid = s1_adv || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= '0;
            r_byte_count  <= '0;
            r_rx_mode     <= 1'b0;
            r_start_index <= '0;
            r_pos         <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEV_ADDR:   r_dev_addr    <= i_cfg_data;
                    CFG_BYTE_COUNT: r_byte_count  <= i_cfg_data[5:0];
                    CFG_RX_MODE:    r_rx_mode     <= i_cfg_data[0];
                    CFG_START_IDX:  r_start_index <= i_cfg_data[4:0];
                endcase
            end
            if (in_acc) begin
                r_pos <= n_pos;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_valid      = r_out.tx_valid;
    assign o_tx_byte       = r_out.tx_byte;
    assign o_send_start    = r_out.send_start;
    assign o_send_stop     = r_out.send_stop;
    assign o_send_ack      = r_out.send_ack;
    assign o_clear_flag    = r_out.clear_flag;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_index      = r_out.rx_index;
    assign o_rx_byte       = r_out.rx_byte;
    assign o_done_res      = r_out.done_res;
    assign o_timeout_clear = r_out.timeout_clear;
    assign o_unhandled     = r_out.unhandled;
endmodule

// ----- sv/i2cms_checker.sv -----
`include "i2c_master_status_sequencer_macros.svh"

module i2cms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_send_stop,
    input logic       o_clear_flag,
    input logic       o_rx_valid,
    input logic       o_done_res,
    input logic       o_timeout_clear,
    input logic       o_unhandled
);
    // stalled beat holds
    `I2CMS_ASSERT(a_stall_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_tx_byte) && $stable(o_done_res)), "result beat changed while stalled")
    `I2CMS_IMPLY(a_done_stop, o_valid && o_done_res, o_send_stop && o_clear_flag, "done without stop and flag clear")
    `I2CMS_IMPLY(a_tmo_alone, o_valid && o_timeout_clear, !o_tx_valid && !o_clear_flag && !o_rx_valid && !o_unhandled, "timeout beat carries other actions")
    `I2CMS_IMPLY(a_rx_no_tx, o_valid && o_rx_valid, !o_tx_valid && o_clear_flag, "receive beat also transmits")
endmodule

bind i2c_master_status_sequencer i2cms_checker u_i2cms_checker (.*);

// ----- sim/tb_i2c_master_status_sequencer.sv -----
module tb_i2c_master_status_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         BUF_BYTES   = 32;
    localparam int         QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] status;
        logic       tmo;
        logic [7:0] rxd;
        logic [4:0] lidx;
        logic [7:0] lbyte;
    } t_ctl_item;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [6:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_func;
    logic [7:0] i_status_code;
    logic       i_timeout_seen;
    logic [7:0] i_rx_data;
    logic [4:0] i_load_index;
    logic [7:0] i_load_byte;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_send_start;
    logic       o_send_stop;
    logic       o_send_ack;
    logic       o_clear_flag;
    logic       o_rx_valid;
    logic [4:0] o_rx_index;
    logic [7:0] o_rx_byte;
    logic       o_done_res;
    logic       o_timeout_clear;
    logic       o_unhandled;

    t_ctl_item  cur_item = '0;
    t_ctl_item  pend_q[$];
    t_result    action_q[$];

    // sequencer state as the testbench sees it
    logic [7:0] shadow_buf [BUF_BYTES];
    logic [5:0] cur_pos   = '0;
    logic [6:0] cfg_addr  = '0;
    logic [5:0] cfg_count = '0;
    logic       cfg_rx    = 1'b0;
    logic [4:0] cfg_start = '0;

    int         send_gap    = 0;
    int         recv_wait   = 0;
    logic       send_calm   = 1'b0;
    logic       recv_calm   = 1'b0;
    int         quiet_cycles = 0;
    int         err_count   = 0;
    int         queued      = 0;

    assign i_func         = cur_item.func;
    assign i_status_code  = cur_item.status;
    assign i_timeout_seen = cur_item.tmo;
    assign i_rx_data      = cur_item.rxd;
    assign i_load_index   = cur_item.lidx;
    assign i_load_byte    = cur_item.lbyte;

    i2c_master_status_sequencer u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic t_result with_tx(input t_result r);
        r.tx_valid   = 1'b1;
        r.tx_byte    = (cur_pos < BUF_BYTES) ? shadow_buf[cur_pos[4:0]] : 8'h00;
        r.clear_flag = 1'b1;
        cur_pos      = cur_pos + 6'd1;
        return r;
    endfunction

    function automatic t_result with_rx(input t_result r, input logic [7:0] data);
        if (cur_pos < BUF_BYTES)
            shadow_buf[cur_pos[4:0]] = data;
        r.rx_valid = 1'b1;
        r.rx_index = cur_pos[4:0];
        r.rx_byte  = data;
        cur_pos    = cur_pos + 6'd1;
        return r;
    endfunction

    function automatic t_result next_action(input t_ctl_item it);
        t_result r;
        r = '0;
        case (it.func)
            FUNC_LOAD: shadow_buf[it.lidx] = it.lbyte;
            FUNC_BEGIN: begin
                cur_pos      = {1'b0, cfg_start};
                r.send_start = 1'b1;
            end
            FUNC_STATUS: begin
                if (it.tmo) begin
                    r.timeout_clear = 1'b1;
                end else begin
                    case (it.status)
                        ST_START: begin
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = {cfg_addr, cur_pos != 6'd0};
                            r.clear_flag = 1'b1;
                        end
                        ST_RSTART: begin
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = {cfg_addr, RW_READ};
                            r.clear_flag = 1'b1;
                        end
                        ST_ADDRW_ACK: r = with_tx(r);
                        ST_ADDRW_NACK, ST_TXDATA_NACK: begin
                            r.send_start = 1'b1;
                            r.send_stop  = 1'b1;
                            r.clear_flag = 1'b1;
                        end
                        ST_TXDATA_ACK: begin
                            if (cfg_rx) begin
                                if (cur_pos < CMD_BYTES) begin
                                    r = with_tx(r);
                                end else begin
                                    // command bytes out, turn around with repeated start
                                    r.send_start = 1'b1;
                                    r.clear_flag = 1'b1;
                                end
                            end else if (cur_pos < cfg_count) begin
                                r = with_tx(r);
                            end else begin
                                r.send_stop  = 1'b1;
                                r.clear_flag = 1'b1;
                                r.done_res   = 1'b1;
                            end
                        end
                        ST_ADDRR_ACK: begin
                            r.clear_flag = 1'b1;
                            r.send_ack   = (int'(cur_pos) + 1 < int'(cfg_count));
                        end
                        ST_RXDATA_ACK: begin
                            r            = with_rx(r, it.rxd);
                            r.clear_flag = 1'b1;
                            // ack decision uses the position after the store
                            r.send_ack   = (int'(cur_pos) + 1 < int'(cfg_count));
                        end
                        ST_RXDATA_NACK: begin
                            r            = with_rx(r, it.rxd);
                            r.send_stop  = 1'b1;
                            r.clear_flag = 1'b1;
                            r.done_res   = 1'b1;
                        end
                        default: r.unhandled = 1'b1;
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic report_error(input string what);
        if (err_count < 100)
            $display("%0t ERROR %s", $time, what);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_action(input t_result got);
        t_result want;
        if (action_q.size() == 0) begin
            report_error($sformatf("result beat with nothing pending: %h", got));
        end else begin
            want = action_q.pop_front();
            cmp_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
            cmp_field("tx_byte", got.tx_byte, want.tx_byte);
            cmp_field("send_start", 8'(got.send_start), 8'(want.send_start));
            cmp_field("send_stop", 8'(got.send_stop), 8'(want.send_stop));
            cmp_field("send_ack", 8'(got.send_ack), 8'(want.send_ack));
            cmp_field("clear_flag", 8'(got.clear_flag), 8'(want.clear_flag));
            cmp_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
            cmp_field("rx_index", 8'(got.rx_index), 8'(want.rx_index));
            cmp_field("rx_byte", got.rx_byte, want.rx_byte);
            cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
            cmp_field("timeout_clear", 8'(got.timeout_clear), 8'(want.timeout_clear));
            cmp_field("unhandled", 8'(got.unhandled), 8'(want.unhandled));
        end
    endtask

    // ---------------- driver / monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                action_q.push_back(next_action(cur_item));
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pend_q.size() != 0) begin
                    cur_item <= pend_q.pop_front();
                    i_valid  <= 1'b1;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 8);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 63) == 0)
                send_calm <= !send_calm;
        end
    end

    always @(posedge i_clk) begin : recv_side
        int hold;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            hold = recv_wait;
            if (o_valid && i_ready) begin
                check_action({o_tx_valid, o_tx_byte, o_send_start, o_send_stop, o_send_ack,
                              o_clear_flag, o_rx_valid, o_rx_index, o_rx_byte, o_done_res,
                              o_timeout_clear, o_unhandled});
                hold = recv_calm ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                i_ready   <= 1'b0;
                recv_wait <= hold - 1;
            end else begin
                i_ready   <= 1'b1;
                recv_wait <= 0;
            end
            if ($urandom_range(0, 63) == 0)
                recv_calm <= !recv_calm;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic rare();
        return $urandom_range(0, 24) == 0;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] any_code();
        case ($urandom_range(0, 8))
            0: return ST_START;
            1: return ST_RSTART;
            2: return ST_ADDRW_ACK;
            3: return ST_ADDRW_NACK;
            4: return ST_TXDATA_ACK;
            5: return ST_TXDATA_NACK;
            6: return ST_ADDRR_ACK;
            7: return ST_RXDATA_ACK;
            default: return ST_RXDATA_NACK;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] func, input logic [7:0] status, input logic tmo,
                             input logic [7:0] rxd, input logic [4:0] lidx,
                             input logic [7:0] lbyte);
        t_ctl_item it;
        it.func   = func;
        it.status = status;
        it.tmo    = tmo;
        it.rxd    = rxd;
        it.lidx   = lidx;
        it.lbyte  = lbyte;
        pend_q.push_back(it);
        queued++;
    endtask

    task automatic push_status(input logic [7:0] code, input logic tmo);
        push_item(FUNC_STATUS, code, tmo, rand_byte(), 5'($urandom_range(0, 31)), rand_byte());
    endtask

    task automatic push_load(input logic [4:0] idx, input logic [7:0] data);
        push_item(FUNC_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rand_byte(),
                  idx, data);
    endtask

    task automatic push_begin();
        push_item(FUNC_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rand_byte(),
                  5'($urandom_range(0, 31)), rand_byte());
    endtask

    task automatic push_noise();
        logic [1:0] f;
        logic [7:0] code;
        f    = ($urandom_range(0, 15) == 0) ? FUNC_SPARE : 2'($urandom_range(0, 2));
        code = $urandom_range(0, 1) ? any_code() : 8'($urandom_range(0, 255));
        push_item(f, code, $urandom_range(0, 3) == 0, rand_byte(), 5'($urandom_range(0, 31)),
                  rand_byte());
    endtask

    task automatic write_txn();
        int p;
        push_begin();
        push_status(ST_START, rare());
        if ($urandom_range(0, 9) == 0) begin
            push_status(ST_ADDRW_NACK, 1'b0);
        end else begin
            push_status(ST_ADDRW_ACK, rare());
            p = cfg_start + 1;
            while (p < cfg_count) begin
                push_status(ST_TXDATA_ACK, rare());
                p++;
            end
            if ($urandom_range(0, 9) == 0)
                push_status(ST_TXDATA_NACK, 1'b0);
            else
                push_status(ST_TXDATA_ACK, rare());
        end
    endtask

    task automatic read_txn();
        push_begin();
        if (cfg_start == 5'd0) begin
            push_status(ST_START, rare());
            push_status(ST_ADDRW_ACK, rare());
            push_status(ST_TXDATA_ACK, rare());
            push_status(ST_TXDATA_ACK, rare());
            push_status(ST_TXDATA_ACK, rare());
            push_status(ST_RSTART, rare());
        end else begin
            // plain read: address goes out with the read bit straight away
            push_status(ST_START, rare());
        end
        push_status(ST_ADDRR_ACK, rare());
        repeat ($urandom_range(0, 7))
            push_status(ST_RXDATA_ACK, rare());
        push_status(ST_RXDATA_NACK, rare());
    endtask

    // walk position past the end of the buffer and through the wrap
    task automatic overrun_buffer();
        push_begin();
        repeat ($urandom_range(34, 70))
            push_status($urandom_range(0, 1) ? ST_ADDRW_ACK : ST_RXDATA_ACK, rare());
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || i_valid || action_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic set_config(input logic [6:0] addr, input logic [5:0] count, input logic rx,
                              input logic [4:0] start);
        wait_idle();
        write_reg(CFG_DEV_ADDR, addr);
        write_reg(CFG_BYTE_COUNT, {1'b0, count});
        write_reg(CFG_RX_MODE, {6'd0, rx});
        write_reg(CFG_START_IDX, {2'd0, start});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        cfg_addr  = addr;
        cfg_count = count;
        cfg_rx    = rx;
        cfg_start = start;
    endtask

    initial begin : stimulus
        int         ph;
        int         stop_at;
        int         pick;
        logic       rx;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // buffer comes up as garbage: fill every entry before anything reads it
        for (int i = 0; i < BUF_BYTES; i++)
            push_load(5'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : rand_byte());

        // directed: write transaction of three bytes plus the odd cases
        set_config(7'h7F, 6'd3, 1'b0, 5'd0);
        push_item(FUNC_SPARE, 8'hFF, 1'b1, 8'hFF, 5'd31, 8'hFF);
        push_status(ST_TXDATA_ACK, 1'b1);
        push_status(8'h00, 1'b0);
        push_status(8'hFF, 1'b0);
        push_begin();
        push_status(ST_START, 1'b0);
        push_status(ST_ADDRW_ACK, 1'b0);
        repeat (3) push_status(ST_TXDATA_ACK, 1'b0);
        push_status(ST_ADDRW_NACK, 1'b0);
        push_status(ST_TXDATA_NACK, 1'b0);
        push_status(ST_RSTART, 1'b0);
        push_status(ST_ADDRR_ACK, 1'b0);
        push_status(ST_RXDATA_ACK, 1'b0);
        push_status(ST_RXDATA_NACK, 1'b0);

        // directed: command-then-read
        set_config(7'h00, 6'd32, 1'b1, 5'd0);
        push_begin();
        push_status(ST_START, 1'b0);
        push_status(ST_ADDRW_ACK, 1'b0);
        push_status(ST_TXDATA_ACK, 1'b0);
        push_status(ST_TXDATA_ACK, 1'b0);
        push_status(ST_RSTART, 1'b0);
        push_status(ST_ADDRR_ACK, 1'b0);
        push_status(ST_RXDATA_ACK, 1'b0);
        push_status(ST_RXDATA_NACK, 1'b0);

        for (ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_config(7'h00, 6'd0, 1'b0, 5'd0);
                1: set_config(7'h7F, 6'd32, 1'b1, 5'd31);
                2: set_config(7'h7F, 6'd32, 1'b0, 5'd31);
                3: set_config(7'h2A, 6'd1, 1'b1, 5'd0);
                default: begin
                    rx = 1'($urandom_range(0, 1));
                    set_config(7'($urandom_range(0, 127)),
                               ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 32))
                                                           : 6'($urandom_range(0, 8)),
                               rx,
                               rx ? (($urandom_range(0, 1) == 0) ? 5'd0
                                                                 : 5'($urandom_range(1, 31)))
                                  : (($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                 : 5'($urandom_range(0, 4))));
                end
            endcase
            stop_at = queued + 120;
            while (queued < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    if (cfg_rx)
                        read_txn();
                    else
                        write_txn();
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 3))
                        push_load(5'($urandom_range(0, 31)), rand_byte());
                end else if (pick < 93) begin
                    repeat ($urandom_range(1, 4))
                        push_noise();
                end else begin
                    overrun_buffer();
                end
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- i2c_master_status_sequencer.f -----
+incdir+sv
sv/i2cms_pkg.sv
sv/i2cms_ram.sv
sv/i2c_master_status_sequencer.sv
sv/i2cms_checker.sv
sim/tb_i2c_master_status_sequencer.sv
